>>> rtl/core/urm_pkg.sv
// shared types and constants for the ultrasonic ranger median block
package urm_pkg;

   localparam int MAX_SAMPLES = 16;
   localparam int SLOT_W      = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);

   localparam int SAMPLE_COUNT_W = 5;
   localparam int TIMEOUT_W      = 16;
   localparam int RETRY_W        = 4;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 16;
   localparam int DIST_W         = 12;
   localparam int CM_W           = 11;
   localparam int REM_W          = 6;

   localparam logic [SAMPLE_COUNT_W-1:0] SAMPLE_COUNT_RST = SAMPLE_COUNT_W'(5);
   localparam logic [TIMEOUT_W-1:0]      ECHO_TIMEOUT_RST = TIMEOUT_W'(20000);
   localparam logic [RETRY_W-1:0]        RETRY_LIMIT_RST  = RETRY_W'(10);

   localparam logic [TIMEOUT_W-1:0] TRIG_LOW_TICKS  = TIMEOUT_W'(2);
   localparam logic [TIMEOUT_W-1:0] TRIG_HIGH_TICKS = TIMEOUT_W'(10);
   localparam logic [REM_W-1:0]     US_PER_CM_LAST  = REM_W'(58 - 1);

   // register indexes on the csr port
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_ECHO_TIMEOUT = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_RETRY_LIMIT  = CSR_INDEX_W'(2);

   typedef logic signed [DIST_W-1:0] sample_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_LOW  = 3'd1,
      PH_HIGH = 3'd2,
      PH_WAIT = 3'd3,
      PH_MEAS = 3'd4
   } phase_type;

   typedef struct packed {
      logic echo_level;
      logic start_req;
   } req_type;

   typedef struct packed {
      logic       trigger;
      logic       busy_res;
      logic       done_res;
      sample_type distance_cm;
   } rsp_type;

   // control from the sequencer to the sample sorter
   typedef struct packed {
      logic              insert_en;
      logic [SLOT_W-1:0] slot;
      sample_type        value;
      logic [SLOT_W-1:0] median_idx;
   } sort_ctl_type;

endpackage

>>> rtl/core/urm_sorter.sv
// sorted sample store with parallel insertion and median read
module urm_sorter (
   input  logic                  clock,
   input  urm_pkg::sort_ctl_type ctl,
   output urm_pkg::sample_type   median
);

   urm_pkg::sample_type samples_ff [urm_pkg::MAX_SAMPLES];
   urm_pkg::sample_type samples_in [urm_pkg::MAX_SAMPLES];
   logic [urm_pkg::MAX_SAMPLES-1:0] gt;

   for (genvar j = 0; j < urm_pkg::MAX_SAMPLES; j++) begin : g_slot
      // held entries above the new value form a suffix below the slot
      assign gt[j] = (urm_pkg::SLOT_W'(j) < ctl.slot) && (samples_ff[j] > ctl.value);

      if (j == 0) begin : g_first
         always_comb begin
            if (urm_pkg::SLOT_W'(j) > ctl.slot) begin
               samples_in[j] = samples_ff[j];
            end else if (ctl.slot == urm_pkg::SLOT_W'(j) || gt[j]) begin
               samples_in[j] = ctl.value;
            end else begin
               samples_in[j] = samples_ff[j];
            end
         end
      end else begin : g_rest
         always_comb begin
            if (urm_pkg::SLOT_W'(j) > ctl.slot) begin
               samples_in[j] = samples_ff[j];
            end else if (gt[j-1]) begin
               samples_in[j] = samples_ff[j-1];
            end else if (ctl.slot == urm_pkg::SLOT_W'(j) || gt[j]) begin
               samples_in[j] = ctl.value;
            end else begin
               samples_in[j] = samples_ff[j];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.insert_en) begin
         samples_ff <= samples_in;
      end
   end

   assign median = samples_in[ctl.median_idx];

endmodule

>>> rtl/core/ultrasonic_ranger_median.sv
// ultrasonic ranger top level: trigger sequencing, echo timing and median output
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_ready   echo_level, start_req (one tick)
//   rsp      out        rsp_valid/rsp_ready   trigger, busy_res, done_res, distance_cm
//   csr      in         csr_we                csr_index, csr_wdata
//
// one word per clock while the rsp side is not stalled: a tick moves from the input
// register through the sequencer into the result register
// the sequencer state updates only when a tick is passed on to the result register
// a stalled rsp side holds the result register; the input register takes
// a word while it is empty or while the result register is free or being drained
// synchronous reset; the sample store has no reset and needs no clearing pass
module ultrasonic_ranger_median (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  urm_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output urm_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_we,
   input  logic [urm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [urm_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   // configuration registers
   logic [urm_pkg::SAMPLE_COUNT_W-1:0] sample_count_ff;
   logic [urm_pkg::TIMEOUT_W-1:0]      echo_timeout_ff;
   logic [urm_pkg::RETRY_W-1:0]        retry_limit_ff;

   // input and result stages
   logic              in_valid_ff;
   urm_pkg::req_type  in_data_ff;
   logic              out_valid_ff;
   urm_pkg::rsp_type  out_data_ff;
   urm_pkg::rsp_type  out_data_in;
   logic              fire;

   // sequencer state; echo width is kept as centimetres plus a remainder mod 58
   urm_pkg::phase_type             phase_ff, phase_in;
   logic [urm_pkg::TIMEOUT_W-1:0]  elapsed_ff, elapsed_in;
   logic [urm_pkg::CM_W-1:0]       cm_ff, cm_in;
   logic [urm_pkg::REM_W-1:0]      rem_ff, rem_in;
   logic [urm_pkg::RETRY_W-1:0]    tries_ff, tries_in;
   logic [urm_pkg::CNT_W-1:0]      taken_ff, taken_in;

   logic [urm_pkg::RETRY_W-1:0]        tries_inc;
   logic [urm_pkg::SAMPLE_COUNT_W-1:0] eff_count;
   logic                               have;
   logic                               done;
   logic                               trig;
   urm_pkg::sample_type                sample;
   urm_pkg::sort_ctl_type              sort_ctl;
   urm_pkg::sample_type                median;

   // a tick moves on when the result register is empty or being drained
   assign fire      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // csr writes, truncated to each register's width
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= urm_pkg::SAMPLE_COUNT_RST;
         echo_timeout_ff <= urm_pkg::ECHO_TIMEOUT_RST;
         retry_limit_ff  <= urm_pkg::RETRY_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            urm_pkg::CSR_SAMPLE_COUNT: begin
               sample_count_ff <= csr_wdata[urm_pkg::SAMPLE_COUNT_W-1:0];
            end
            urm_pkg::CSR_ECHO_TIMEOUT: begin
               echo_timeout_ff <= csr_wdata[urm_pkg::TIMEOUT_W-1:0];
            end
            urm_pkg::CSR_RETRY_LIMIT: begin
               retry_limit_ff <= csr_wdata[urm_pkg::RETRY_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // clamp sample count into 1..MAX_SAMPLES
   always_comb begin
      if (sample_count_ff == '0) begin
         eff_count = urm_pkg::SAMPLE_COUNT_W'(1);
      end else if (sample_count_ff > urm_pkg::SAMPLE_COUNT_W'(urm_pkg::MAX_SAMPLES)) begin
         eff_count = urm_pkg::SAMPLE_COUNT_W'(urm_pkg::MAX_SAMPLES);
      end else begin
         eff_count = sample_count_ff;
      end
   end

   assign tries_inc = tries_ff + urm_pkg::RETRY_W'(1);

   // next state of the sequencer for the tick in the input register
   always_comb begin
      phase_in   = phase_ff;
      elapsed_in = elapsed_ff;
      cm_in      = cm_ff;
      rem_in     = rem_ff;
      tries_in   = tries_ff;
      taken_in   = taken_ff;
      trig       = 1'b0;
      have       = 1'b0;
      done       = 1'b0;
      sample     = '0;

      case (phase_ff)
         urm_pkg::PH_IDLE: begin
            // start tick is the first low trigger tick
            if (in_data_ff.start_req) begin
               taken_in   = '0;
               tries_in   = '0;
               cm_in      = '0;
               rem_in     = '0;
               elapsed_in = urm_pkg::TIMEOUT_W'(1);
               phase_in   = urm_pkg::PH_LOW;
            end
         end
         urm_pkg::PH_LOW: begin
            elapsed_in = elapsed_ff + urm_pkg::TIMEOUT_W'(1);
            if (elapsed_in >= urm_pkg::TRIG_LOW_TICKS) begin
               phase_in   = urm_pkg::PH_HIGH;
               elapsed_in = '0;
            end
         end
         urm_pkg::PH_HIGH: begin
            trig       = 1'b1;
            elapsed_in = elapsed_ff + urm_pkg::TIMEOUT_W'(1);
            if (elapsed_in >= urm_pkg::TRIG_HIGH_TICKS) begin
               phase_in   = urm_pkg::PH_WAIT;
               elapsed_in = '0;
            end
         end
         urm_pkg::PH_WAIT, urm_pkg::PH_MEAS: begin
            if (elapsed_ff >= echo_timeout_ff) begin
               // failed try; a retry limit of zero acts as one
               tries_in = tries_inc;
               if (tries_inc >= retry_limit_ff || tries_inc == '0) begin
                  have   = 1'b1;
                  sample = '1;
               end else begin
                  phase_in   = urm_pkg::PH_LOW;
                  elapsed_in = '0;
               end
            end else if (phase_ff == urm_pkg::PH_WAIT) begin
               if (in_data_ff.echo_level) begin
                  phase_in = urm_pkg::PH_MEAS;
                  cm_in    = '0;
                  rem_in   = urm_pkg::REM_W'(1);
               end
               elapsed_in = elapsed_ff + urm_pkg::TIMEOUT_W'(1);
            end else if (in_data_ff.echo_level) begin
               if (rem_ff == urm_pkg::US_PER_CM_LAST) begin
                  rem_in = '0;
                  cm_in  = cm_ff + urm_pkg::CM_W'(1);
               end else begin
                  rem_in = rem_ff + urm_pkg::REM_W'(1);
               end
               elapsed_in = elapsed_ff + urm_pkg::TIMEOUT_W'(1);
            end else begin
               // echo fell: width / 58 is already in cm_ff
               have   = 1'b1;
               sample = urm_pkg::sample_type'({1'b0, cm_ff});
            end
         end
         default: begin
            phase_in = urm_pkg::PH_IDLE;
         end
      endcase

      if (have) begin
         cm_in      = '0;
         rem_in     = '0;
         elapsed_in = '0;
         tries_in   = '0;
         if (taken_ff < urm_pkg::CNT_W'(urm_pkg::MAX_SAMPLES)) begin
            taken_in = taken_ff + urm_pkg::CNT_W'(1);
         end
         if (urm_pkg::SAMPLE_COUNT_W'(taken_in) >= eff_count) begin
            done     = 1'b1;
            phase_in = urm_pkg::PH_IDLE;
         end else begin
            phase_in = urm_pkg::PH_LOW;
         end
      end
   end

   // insertion slot is the held count, capped at the last entry
   always_comb begin
      sort_ctl.insert_en = fire && have;
      sort_ctl.value     = sample;
      if (taken_ff >= urm_pkg::CNT_W'(urm_pkg::MAX_SAMPLES)) begin
         sort_ctl.slot = urm_pkg::SLOT_W'(urm_pkg::MAX_SAMPLES - 1);
      end else begin
         sort_ctl.slot = taken_ff[urm_pkg::SLOT_W-1:0];
      end
      sort_ctl.median_idx = urm_pkg::SLOT_W'(eff_count >> 1);
   end

   urm_sorter u_sorter (
      .clock  (clock),
      .ctl    (sort_ctl),
      .median (median)
   );

   always_comb begin
      out_data_in.trigger     = trig;
      out_data_in.busy_res    = (phase_in != urm_pkg::PH_IDLE);
      out_data_in.done_res    = done;
      out_data_in.distance_cm = done ? median : '0;
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_data_ff <= out_data_in;
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= urm_pkg::PH_IDLE;
         elapsed_ff <= '0;
         cm_ff      <= '0;
         rem_ff     <= '0;
         tries_ff   <= '0;
         taken_ff   <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         elapsed_ff <= elapsed_in;
         cm_ff      <= cm_in;
         rem_ff     <= rem_in;
         tries_ff   <= tries_in;
         taken_ff   <= taken_in;
      end
   end

endmodule

>>> rtl/core/urm_checker.sv
// port-level checks for the ultrasonic ranger median block
module urm_assertions (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input urm_pkg::rsp_type rsp_data
);

   // the done word ends the sequence
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.done_res) |-> !rsp_data.busy_res)
      else $error("done word still shows busy");

   // distance only carries a value on the done word
   a_dist_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.done_res) |-> (rsp_data.distance_cm == '0))
      else $error("distance nonzero without done");

   // trigger only pulses inside a running sequence
   a_trig_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.trigger) |-> rsp_data.busy_res)
      else $error("trigger high while idle");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result word changed under stall");

endmodule

bind ultrasonic_ranger_median urm_assertions u_urm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
